>>> hw/rtl/ols_pkg.sv
// Shared constants, codes and the command type for the ordered list store.
package ols_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int POS_BITS   = 5;
    localparam int CQ_DEPTH   = 2;
    localparam int CQ_PTR     = $clog2(CQ_DEPTH);
    localparam int CQ_CNT     = $clog2(CQ_DEPTH + 1);

    localparam logic [1:0] K_APPEND = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_FIND   = 2'd2;
    localparam logic [1:0] K_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  is_write;
        logic [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]   position;
    } t_cmd;

endpackage

>>> hw/rtl/ols_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ols_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ols_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module ols_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_kind,
    input  logic [ols_pkg::VALUE_BITS-1:0] i_value,
    input  logic [ols_pkg::POS_BITS-1:0]  i_position,
    output logic                          o_cmd_valid,
    output ols_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_pop
);
    import ols_pkg::*;

    t_cmd              r_q [CQ_DEPTH];
    logic [CQ_PTR-1:0] r_wp, n_wp;
    logic [CQ_PTR-1:0] r_rp, n_rp;
    logic [CQ_CNT-1:0] r_cnt, n_cnt;
    logic              w_push;
    logic              w_pop;
    t_cmd              w_new;

    assign o_full      = (r_cnt == CQ_CNT'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        w_new.kind     = i_kind;
        w_new.is_write = (i_kind == K_APPEND) || (i_kind == K_INSERT);
        w_new.value    = i_value;
        w_new.position = i_position;
        n_wp  = w_push ? CQ_PTR'(r_wp + 1'b1) : r_wp;
        n_rp  = w_pop  ? CQ_PTR'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = CQ_CNT'(r_cnt + 1'b1);
        end else if (w_pop && !w_push) begin
            n_cnt = CQ_CNT'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

endmodule

>>> hw/rtl/ols_back.sv
// Back end: walks the entry memory to carry out each request and holds the result.
module ols_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  ols_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [1:0]                    o_status,
    output logic [3:0]                    o_found_index,
    output logic [4:0]                    o_length
);
    import ols_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RES  = 3'd1;
    localparam logic [2:0] S_URD  = 3'd2;
    localparam logic [2:0] S_UWR  = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SCMP = 3'd5;
    localparam logic [2:0] S_DRD  = 3'd6;
    localparam logic [2:0] S_DWR  = 3'd7;

    logic [2:0]            r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    t_cmd                  r_cmd, n_cmd;
    logic [1:0]            r_status, n_status;
    logic [IDX_BITS-1:0]   r_fidx, n_fidx;
    logic                  r_res_valid, n_res_valid;
    logic [1:0]            r_res_status, n_res_status;
    logic [3:0]            r_res_fidx, n_res_fidx;
    logic [4:0]            r_res_len, n_res_len;

    logic                  w_we;
    logic [IDX_BITS-1:0]   w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [IDX_BITS-1:0]   w_raddr;
    logic [VALUE_BITS-1:0] w_rdata;
    logic [CNT_BITS-1:0]   w_idx_m1;
    logic [CNT_BITS-1:0]   w_idx_p1;
    logic                  w_slot_free;

    ols_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_idx_m1    = CNT_BITS'(r_idx - 1'b1);
    assign w_idx_p1    = CNT_BITS'(r_idx + 1'b1);
    assign w_slot_free = !r_res_valid || i_pop;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_fidx       = r_fidx;
        n_res_valid  = r_res_valid && !i_pop;
        n_res_status = r_res_status;
        n_res_fidx   = r_res_fidx;
        n_res_len    = r_res_len;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_raddr      = '0;
        o_cmd_pop    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_status  = ST_OK;
                    n_fidx    = '0;
                    priority if (i_cmd.is_write && r_count == CNT_BITS'(DEPTH)) begin
                        n_status = ST_FULL;
                        n_state  = S_RES;
                    end else if (i_cmd.kind == K_APPEND) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IDX_BITS-1:0];
                        w_wdata = i_cmd.value;
                        n_count = CNT_BITS'(r_count + 1'b1);
                        n_state = S_RES;
                    end else if (i_cmd.kind == K_INSERT) begin
                        if (i_cmd.position > r_count) begin
                            n_status = ST_BADPOS;
                            n_state  = S_RES;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_URD;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_RES;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SRD;
                    end
                end
            end
            S_URD: begin
                if (r_idx == CNT_BITS'(r_cmd.position)) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IDX_BITS-1:0];
                    w_wdata = r_cmd.value;
                    n_count = CNT_BITS'(r_count + 1'b1);
                    n_state = S_RES;
                end else begin
                    w_raddr = w_idx_m1[IDX_BITS-1:0];
                    n_state = S_UWR;
                end
            end
            S_UWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_BITS-1:0];
                w_wdata = w_rdata;
                n_idx   = w_idx_m1;
                n_state = S_URD;
            end
            S_SRD: begin
                w_raddr = r_idx[IDX_BITS-1:0];
                n_state = S_SCMP;
            end
            S_SCMP: begin
                priority if (w_rdata == r_cmd.value) begin
                    if (r_cmd.kind == K_FIND) begin
                        n_fidx  = r_idx[IDX_BITS-1:0];
                        n_state = S_RES;
                    end else begin
                        n_state = S_DRD;
                    end
                end else if (w_idx_p1 == r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RES;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_SRD;
                end
            end
            S_DRD: begin
                if (w_idx_p1 >= r_count) begin
                    n_count = CNT_BITS'(r_count - 1'b1);
                    n_state = S_RES;
                end else begin
                    w_raddr = w_idx_p1[IDX_BITS-1:0];
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_BITS-1:0];
                w_wdata = w_rdata;
                n_idx   = w_idx_p1;
                n_state = S_DRD;
            end
            S_RES: begin
                if (w_slot_free) begin
                    n_res_valid  = 1'b1;
                    n_res_status = r_status;
                    n_res_fidx   = 4'(r_fidx);
                    n_res_len    = 5'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cmd        <= n_cmd;
        r_status     <= n_status;
        r_fidx       <= n_fidx;
        r_res_status <= n_res_status;
        r_res_fidx   <= n_res_fidx;
        r_res_len    <= n_res_len;
    end

    assign o_empty       = !r_res_valid;
    assign o_status      = r_res_status;
    assign o_found_index = r_res_fidx;
    assign o_length      = r_res_len;

endmodule

>>> hw/rtl/ordered_list_store.sv
// Top level of the ordered list store: request queue, sequencer and result register.
// Append and any rejected request go straight to the result; insert first shifts the entries
// from the position on up by one, find scans from index 0, and delete scans and then shifts down.
// One request is worked at a time: the next is taken once the last result is registered.
// A two-entry request queue takes new requests while the sequencer or result waits.
// Synchronous active-low reset empties the queue and the result and sets the count to 0.
module ordered_list_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_position,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [3:0]  o_found_index,
    output logic [4:0]  o_length
);
    import ols_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    ols_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_kind     (i_kind),
        .i_value    (i_value[VALUE_BITS-1:0]),
        .i_position (i_position),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    ols_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_length     (o_length)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_length <= 5'(DEPTH)))
        else $error("length exceeds capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_FULL) |-> (o_length == 5'(DEPTH)))
        else $error("full status with room left");

    a_fidx_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found_index != 4'd0) |-> (o_status == ST_OK))
        else $error("found index on a failed request");

    a_pop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_pop && !cmd_valid) |-> 1'b0)
        else $error("sequencer took a request from an empty queue");

endmodule

>>> tb/ordered_list_store_tb.sv
// Self-checking testbench for the ordered list store: directed and random requests.
`timescale 1ns / 100ps

module ordered_list_store_tb;
    import ols_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_index;
        logic [4:0] length;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_kind = K_APPEND;
    logic [31:0] i_value = '0;
    logic [4:0]  i_position = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_found_index;
    logic [4:0]  o_length;

    logic [31:0]  list_vals [DEPTH];
    int           list_len = 0;
    t_list_result due_replies [$];
    t_list_result want;

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int pop_hold = 0;
    int fail_count = 0;
    int checked_count = 0;
    int kind_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};

    ordered_list_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_position    (i_position),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_length      (o_length)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_list_result predict_list_op(input logic [1:0] kind,
                                                     input logic [31:0] value,
                                                     input logic [4:0] pos);
        t_list_result r;
        int hit;
        r.status = ST_OK;
        r.found_index = '0;
        hit = -1;
        if (kind == K_FIND || kind == K_DELETE) begin
            for (int i = 0; i < list_len; i++) begin
                if (hit < 0 && list_vals[i] == value) begin
                    hit = i;
                end
            end
        end
        case (kind)
            K_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_vals[list_len] = value;
                    list_len++;
                end
            end
            K_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(pos) > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = list_len; i > int'(pos); i--) begin
                        list_vals[i] = list_vals[i-1];
                    end
                    list_vals[pos] = value;
                    list_len++;
                end
            end
            K_FIND: begin
                if (hit >= 0) begin
                    r.found_index = 4'(hit);
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            default: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < list_len; i++) begin
                        list_vals[i] = list_vals[i+1];
                    end
                    list_len--;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
        endcase
        r.length = 5'(list_len);
        return r;
    endfunction

    task automatic push_request(input logic [1:0] kind, input logic [31:0] value,
                                input logic [4:0] pos);
        if (send_idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        i_position <= pos;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        due_replies.push_back(predict_list_op(kind, value, pos));
        kind_seen[kind]++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_hold = 0;
        end else begin
            if (pop && !empty) begin
                if (due_replies.size() == 0) begin
                    $error("result with no request waiting: status %0d found_index %0d length %0d",
                           o_status, o_found_index, o_length);
                    fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    checked_count++;
                    status_seen[want.status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_found_index !== want.found_index) begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, o_found_index);
                        fail_count++;
                    end
                    if (o_length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, o_length);
                        fail_count++;
                    end
                end
            end
            if (pop_hold > 0) begin
                pop_hold--;
                pop <= 1'b0;
            end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
                pop_hold = $urandom_range(0, 8);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Walks the empty, duplicate, boundary and full-store cases in a fixed order.
    task automatic test_directed_cases();
        push_request(K_FIND, 32'h0000_0000, 5'd0);
        push_request(K_DELETE, 32'h0000_0000, 5'd0);
        push_request(K_INSERT, 32'h0000_0005, 5'd1);
        push_request(K_INSERT, 32'h8000_0000, 5'd0);
        push_request(K_APPEND, 32'h7fff_ffff, 5'd31);
        push_request(K_INSERT, 32'hffff_ffff, 5'd1);
        push_request(K_INSERT, 32'hffff_ffff, 5'd3);
        push_request(K_INSERT, 32'h1234_5678, 5'd16);
        push_request(K_FIND, 32'hffff_ffff, 5'd0);
        push_request(K_DELETE, 32'hffff_ffff, 5'd0);
        push_request(K_FIND, 32'hffff_ffff, 5'd16);
        for (int k = 0; k < 13; k++) begin
            push_request(K_APPEND, 32'(k), 5'(k));
        end
        push_request(K_APPEND, 32'h5555_aaaa, 5'd0);
        push_request(K_INSERT, 32'haaaa_5555, 5'd16);
        push_request(K_FIND, 32'd12, 5'd0);
        push_request(K_DELETE, 32'h8000_0000, 5'd0);
        wait_drained();
    endtask

    // Random mix in segments that lean toward filling, emptying or neither.
    task automatic test_random_mix(input int n_req, input bit with_idle);
        int bias;
        int roll;
        int app_cut;
        int ins_cut;
        int fnd_cut;
        logic [1:0]  kind;
        logic [31:0] value;
        logic [4:0]  pos;
        send_idle_en = with_idle;
        recv_idle_en = with_idle;
        bias = 2;
        for (int n = 0; n < n_req; n++) begin
            if (n % 50 == 0) begin
                bias = $urandom_range(0, 2);
                if (with_idle) begin
                    send_idle_en = ($urandom_range(0, 3) != 0);
                    recv_idle_en = ($urandom_range(0, 3) != 0);
                    if ($urandom_range(0, 3) == 0) begin
                        wait_drained();
                    end
                end
            end
            case (bias)
                0:       begin app_cut = 35; ins_cut = 70; fnd_cut = 85; end
                1:       begin app_cut = 10; ins_cut = 20; fnd_cut = 50; end
                default: begin app_cut = 25; ins_cut = 50; fnd_cut = 75; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < app_cut) begin
                kind = K_APPEND;
            end else if (roll < ins_cut) begin
                kind = K_INSERT;
            end else if (roll < fnd_cut) begin
                kind = K_FIND;
            end else begin
                kind = K_DELETE;
            end
            roll = $urandom_range(0, 9);
            if (roll < 4 && list_len > 0) begin
                value = list_vals[$urandom_range(0, list_len - 1)];
            end else if (roll < 7) begin
                value = 32'(int'($urandom_range(0, 7)) - 4);
            end else begin
                value = $urandom();
            end
            if ($urandom_range(0, 4) == 0) begin
                pos = 5'($urandom_range(0, 16));
            end else begin
                pos = 5'($urandom_range(0, list_len));
            end
            push_request(kind, value, pos);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_mix(1100, 1'b1);
        test_random_mix(60, 1'b0);
        wait_drained();
        repeat (64) @(posedge i_clk);
        $display("Sent %0d requests: %0d appends, %0d inserts, %0d finds, %0d deletes.",
                 kind_seen[K_APPEND] + kind_seen[K_INSERT] + kind_seen[K_FIND]
                 + kind_seen[K_DELETE], kind_seen[K_APPEND], kind_seen[K_INSERT],
                 kind_seen[K_FIND], kind_seen[K_DELETE]);
        $display("Checked %0d results: %0d ok, %0d full, %0d bad position, %0d not found.",
                 checked_count, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
        if (fail_count == 0) begin
            $display("ordered_list_store: match");
        end else begin
            $display("ordered_list_store: mismatch");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Run did not finish in time.");
        $display("ordered_list_store: mismatch");
        $finish;
    end

endmodule
